// File: design/ttdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdg_pkg
// Shared types and constants for the touchpad tap/drag gesture core.
// ----------------------------------------------------------------------------
package ttdg_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int GAIN_W         = 4;
    localparam int THR_W          = 8;
    localparam int WIN_W          = 16;
    localparam int TIME_W         = 32;
    localparam int MOVE_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int OUT_TDATA_W    = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 4'd3;
    localparam logic [THR_W-1:0]  THRESH_RST = 8'd2;
    localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd300;

    typedef struct packed {
        logic              finger_down;
        logic              dragged;
        logic [1:0]        tap_tally;
        logic [TIME_W-1:0] tap_stamp;
    } t_tap_state;

    typedef struct packed {
        logic                     right_click;
        logic                     left_click;
        logic signed [MOVE_W-1:0] move_dy;
        logic signed [MOVE_W-1:0] move_dx;
        logic                     move_valid;
    } t_result;

endpackage

// File: design/ttdg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdg_step
// Per-sample gesture logic: next tap/drag state and the result item.
// ----------------------------------------------------------------------------
module ttdg_step
    import ttdg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_touching,
    input  logic [TIME_W-1:0]     i_time,
    input  logic [COORD_BITS-1:0] i_prev_x,
    input  logic [COORD_BITS-1:0] i_prev_y,
    input  t_tap_state            i_st,
    input  logic [GAIN_W-1:0]     i_gain,
    input  logic [THR_W-1:0]      i_thr,
    input  logic [WIN_W-1:0]      i_win,
    output t_tap_state            o_st,
    output logic                  o_load_prev,
    output t_result               o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + GAIN_W;

    logic signed [DW-1:0] d_x, d_y;
    logic signed [PW-1:0] gain_s, p_x, p_y;
    logic        [PW-1:0] mag_x, mag_y, thr_ext;
    logic signed [31:0]   p32_x, p32_y;
    logic        [MOVE_W-1:0] sat_x, sat_y;
    logic                 move_hit;
    logic [TIME_W-1:0]    elapsed, win_ext;
    logic                 in_window, expired;
    logic [1:0]           tally_inc;

    assign d_x    = $signed({1'b0, i_x}) - $signed({1'b0, i_prev_x});
    assign d_y    = $signed({1'b0, i_y}) - $signed({1'b0, i_prev_y});
    assign gain_s = $signed({{(PW-GAIN_W){1'b0}}, i_gain});
    assign p_x    = PW'(d_x) * gain_s;
    assign p_y    = PW'(d_y) * gain_s;

    assign mag_x   = p_x[PW-1] ? PW'(-p_x) : PW'(p_x);
    assign mag_y   = p_y[PW-1] ? PW'(-p_y) : PW'(p_y);
    assign thr_ext = PW'(i_thr);
    assign move_hit = (mag_x > thr_ext) || (mag_y > thr_ext);

    // clamp to the 16-bit report range
    assign p32_x = 32'(p_x);
    assign p32_y = 32'(p_y);
    assign sat_x = (p32_x > 32'sd32767)  ? 16'h7FFF :
                   (p32_x < -32'sd32768) ? 16'h8000 : p32_x[MOVE_W-1:0];
    assign sat_y = (p32_y > 32'sd32767)  ? 16'h7FFF :
                   (p32_y < -32'sd32768) ? 16'h8000 : p32_y[MOVE_W-1:0];

    assign elapsed   = i_time - i_st.tap_stamp;
    assign win_ext   = TIME_W'(i_win);
    assign in_window = elapsed < win_ext;
    assign expired   = elapsed > win_ext;
    assign tally_inc = i_st.tap_tally + 2'd1;

    assign o_load_prev = i_touching;

    always_comb begin
        o_st  = i_st;
        o_res = '0;
        if (i_touching && !i_st.finger_down) begin
            o_st.finger_down = 1'b1;
            o_st.dragged     = 1'b0;
        end else if (i_touching && i_st.finger_down) begin
            if (move_hit) begin
                o_res.move_valid = 1'b1;
                o_res.move_dx    = sat_x;
                o_res.move_dy    = sat_y;
                o_st.dragged     = 1'b1;
            end
        end else if (!i_touching && i_st.finger_down) begin
            o_st.finger_down = 1'b0;
            if (!i_st.dragged) begin
                if (in_window) begin
                    o_st.tap_tally = tally_inc;
                    if (tally_inc == 2'd2) begin
                        o_res.right_click = 1'b1;
                        o_st.tap_tally    = 2'd0;
                    end
                end else begin
                    o_res.left_click = 1'b1;
                    o_st.tap_tally   = 2'd1;
                    o_st.tap_stamp   = i_time;
                end
            end
        end
        // a fresh stamp means zero elapsed, so expiry only applies otherwise
        if (expired && !o_res.left_click) begin
            o_st.tap_tally = 2'd0;
        end
    end

endmodule

// File: design/touchpad_tap_drag_gesture_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touchpad_tap_drag_gesture_core
// Turns touch samples into relative moves and left/right tap clicks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one touch sample per transaction; m_axis returns exactly
//   one result per sample, in order. Config registers (gain, threshold,
//   double-tap window) are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while the core is idle; indexes beyond the list are ignored.
//   A sample is first registered in the input register and then passes
//   through the step logic into the result register, where it is offered.
//   Throughput: one sample per cycle while m_axis_tready is high; the gesture
//   state updates as the sample moves into the result register, so
//   back-to-back samples see each other's effects.
//   When m_axis_tready is low the result register holds, one more sample
//   waits in the input register, then s_axis_tready drops.
//   Synchronous reset clears the gesture state, empties both registers and
//   loads the register defaults (gain 3, threshold 2, window 300 ms).
// ----------------------------------------------------------------------------
module touchpad_tap_drag_gesture_core
    import ttdg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_FIELDS_W = 2 * COORD_BITS + 1 + TIME_W,
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // samples in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // fields from bit 0: touch_x, touch_y, touching, time_ms, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // results out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // fields from bit 0: move_valid, move_dx, move_dy, left_click,
    // right_click, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [GAIN_W-1:0]     r_gain;
    logic [THR_W-1:0]      r_thr;
    logic [WIN_W-1:0]      r_win;

    logic                  r_in_valid;
    logic [COORD_BITS-1:0] r_in_x, r_in_y;
    logic                  r_in_touch;
    logic [TIME_W-1:0]     r_in_time;

    logic [COORD_BITS-1:0] r_prev_x, r_prev_y;
    t_tap_state            r_tap;

    logic                  r_out_valid;
    t_result               r_out;

    t_tap_state            n_tap;
    t_result               n_out;
    logic                  load_prev;
    logic                  s_fire, advance, step_fire;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    ttdg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_x         (r_in_x),
        .i_y         (r_in_y),
        .i_touching  (r_in_touch),
        .i_time      (r_in_time),
        .i_prev_x    (r_prev_x),
        .i_prev_y    (r_prev_y),
        .i_st        (r_tap),
        .i_gain      (r_gain),
        .i_thr       (r_thr),
        .i_win       (r_win),
        .o_st        (n_tap),
        .o_load_prev (load_prev),
        .o_res       (n_out)
    );

    // control, config and gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_thr       <= THRESH_RST;
            r_win       <= WINDOW_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_tap       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOVE_GAIN:   r_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_MOVE_THRESH: r_thr  <= i_cfg_data[THR_W-1:0];
                    CFG_TAP_WINDOW:  r_win  <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_fire) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end
            if (step_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (step_fire) begin
                r_tap <= n_tap;
                if (load_prev) begin
                    r_prev_x <= r_in_x;
                    r_prev_y <= r_in_y;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_x     <= s_axis_tdata[COORD_BITS-1:0];
            r_in_y     <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_in_touch <= s_axis_tdata[2*COORD_BITS];
            r_in_time  <= s_axis_tdata[2*COORD_BITS+TIME_W:2*COORD_BITS+1];
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

`ifndef NO_ASSERTIONS
    // a tally of two is consumed at once, so three is never reached
    a_tally_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap.tap_tally != 2'd3)
        else $error("tap tally reached 3");

    // a reported move marks the touch as a drag
    a_move_drags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && n_out.move_valid) |=> r_tap.dragged)
        else $error("move without drag mark");

    // one action per result
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_out.move_valid, r_out.left_click,
                                    r_out.right_click}) <= 1)
        else $error("more than one action in a result");
`endif

endmodule
